@@ rtl/mvlom_pkg.sv @@
// Shared types and constants for the motion vector local outlier mask.
// No dependencies; every other file of the block imports this package.
package mvlom_pkg;

	// Vector component and line buffer geometry
	localparam int VEC_W      = 12;
	localparam int LINE_DEPTH = 256;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int ENTRY_W    = 2 * VEC_W + 1;

	// Configuration register widths, row counter width
	localparam int FW_W  = 9;
	localparam int FH_W  = 13;
	localparam int ROW_W = FH_W;

	// Neighborhood sums: nine components need four extra bits
	localparam int SUM_W  = VEC_W + 4;
	localparam int CNT_W  = 4;
	localparam int DIFF_W = SUM_W + 1;

	// Neighborhood sizes: interior, edge, corner
	localparam logic [CNT_W-1:0] N_FULL   = CNT_W'(9);
	localparam logic [CNT_W-1:0] N_EDGE   = CNT_W'(6);
	localparam logic [CNT_W-1:0] N_CORNER = CNT_W'(4);

	// Register limits and reset values
	localparam logic [FW_W-1:0] FW_MIN   = FW_W'(2);
	localparam logic [FW_W-1:0] FW_MAX   = FW_W'(LINE_DEPTH);
	localparam logic [FW_W-1:0] FW_RESET = FW_W'(16);
	localparam logic [FH_W-1:0] FH_MIN   = FH_W'(2);
	localparam logic [FH_W-1:0] FH_MAX   = FH_W'(4096);
	localparam logic [FH_W-1:0] FH_RESET = FH_W'(16);

	// Configuration register indexes
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	// One vector as kept in the line buffers and the window
	typedef struct packed {
		logic                    keep;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] x;
	} vec_t;

	// Position of the window center relative to the field borders
	typedef struct packed {
		logic emit;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} pos_t;

endpackage

@@ rtl/mvlom_line_buf.sv @@
// Line buffer pair (row two back, row one back) in one synchronous memory.
// Read at accept, write back as s1 advances, with forwarding. Uses mvlom_pkg.
module mvlom_line_buf import mvlom_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  vec_t              vec_in,
	output logic              valid_s1,
	output vec_t              up_s1,
	output vec_t              mid_s1,
	output vec_t              new_s1
);

	// entry: upper row in the high half, middle row in the low half
	logic [2*ENTRY_W-1:0] mem [LINE_DEPTH];
	logic [2*ENTRY_W-1:0] rdata_s1;
	logic [2*ENTRY_W-1:0] fwd_data_s1;
	logic [2*ENTRY_W-1:0] entry_s1;
	logic [2*ENTRY_W-1:0] wdata;
	logic [ADDR_W-1:0]    addr_s1;
	logic                 fwd_s1;

	// back-to-back steps on one column see the entry still being written
	assign entry_s1 = fwd_s1 ? fwd_data_s1 : rdata_s1;
	assign up_s1    = vec_t'(entry_s1[2*ENTRY_W-1:ENTRY_W]);
	assign mid_s1   = vec_t'(entry_s1[ENTRY_W-1:0]);
	// middle row moves up, new vector becomes the middle row
	assign wdata    = {mid_s1, new_s1};

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (adv) begin
			valid_s1 <= rd_en;
			fwd_s1   <= rd_en && valid_s1 && (rd_addr == addr_s1);
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1     <= rd_addr;
			new_s1      <= vec_in;
			fwd_data_s1 <= wdata;
		end
	end

	// memory: one read and one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		if (valid_s1 && adv) begin
			mem[addr_s1] <= wdata;
		end
	end

endmodule

@@ rtl/mvlom_window.sv @@
// 3x3 window registers and clipped neighborhood sums.
// Fed by mvlom_line_buf; uses mvlom_pkg.
module mvlom_window import mvlom_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    valid_s1,
	input  pos_t                    pos_s1,
	input  vec_t                    up_s1,
	input  vec_t                    mid_s1,
	input  vec_t                    new_s1,
	output logic                    valid_s3,
	output logic signed [SUM_W-1:0] sum_x_s3,
	output logic signed [SUM_W-1:0] sum_y_s3,
	output logic [CNT_W-1:0]        cnt_s3,
	output vec_t                    ctr_s3,
	output logic                    last_s3
);

	vec_t                    win_q [9];
	logic                    valid_s2;
	pos_t                    pos_s2;
	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;
	logic [CNT_W-1:0]        cnt;
	logic                    row_cut;
	logic                    col_cut;

	// window shift: columns move left, new column from the line buffers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && pos_s2.emit;
			if (valid_s1) begin
				for (int i = 0; i < 3; i++) begin
					win_q[3*i]   <= win_q[3*i+1];
					win_q[3*i+1] <= win_q[3*i+2];
				end
				win_q[2] <= up_s1;
				win_q[5] <= mid_s1;
				win_q[8] <= new_s1;
			end
		end
	end

	// clipped sums over the neighborhood
	always_comb begin
		sum_x = '0;
		sum_y = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!(i == 0 && pos_s2.top) && !(i == 2 && pos_s2.bottom) &&
				    !(j == 0 && pos_s2.left) && !(j == 2 && pos_s2.right)) begin
					sum_x = sum_x + SUM_W'(win_q[3*i+j].x);
					sum_y = sum_y + SUM_W'(win_q[3*i+j].y);
				end
			end
		end
	end

	// neighborhood size
	assign row_cut = pos_s2.top || pos_s2.bottom;
	assign col_cut = pos_s2.left || pos_s2.right;
	always_comb begin
		case ({row_cut, col_cut})
			2'b00:   cnt = N_FULL;
			2'b11:   cnt = N_CORNER;
			default: cnt = N_EDGE;
		endcase
	end

	// position follows the item into the window stage; sums registered
	always_ff @(posedge clk) begin
		if (adv) begin
			if (valid_s1) begin
				pos_s2 <= pos_s1;
			end
			sum_x_s3 <= sum_x;
			sum_y_s3 <= sum_y;
			cnt_s3   <= cnt;
			ctr_s3   <= win_q[4];
			last_s3  <= pos_s2.last;
		end
	end

endmodule

@@ rtl/mvlom_judge.sv @@
// Outlier test on the neighborhood sums and the result register.
// Fed by mvlom_window; uses mvlom_pkg.
module mvlom_judge import mvlom_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    valid_s3,
	input  logic signed [SUM_W-1:0] sum_x_s3,
	input  logic signed [SUM_W-1:0] sum_y_s3,
	input  logic [CNT_W-1:0]        cnt_s3,
	input  vec_t                    ctr_s3,
	input  logic                    last_s3,
	output logic                    out_valid_q,
	output logic                    out_keep_q,
	output logic                    out_last_q
);

	// component passes when 2*|sum - n*v| < 3*n
	function automatic logic passes(input logic signed [SUM_W-1:0] sum,
	                                input logic [CNT_W-1:0] n,
	                                input logic signed [VEC_W-1:0] v);
		logic signed [DIFF_W-1:0] nv;
		logic signed [DIFF_W-1:0] d;
		logic [DIFF_W-1:0]        mag;
		logic [CNT_W:0]           three_n;
		nv      = DIFF_W'(v) * DIFF_W'(signed'({1'b0, n}));
		d       = DIFF_W'(sum) - nv;
		mag     = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
		three_n = {n, 1'b0} + {1'b0, n};
		return {mag, 1'b0} < (DIFF_W+1)'(three_n);
	endfunction

	logic keep;

	assign keep = ctr_s3.keep && passes(sum_x_s3, cnt_s3, ctr_s3.x) &&
	              passes(sum_y_s3, cnt_s3, ctr_s3.y);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s3;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_keep_q <= keep;
			out_last_q <= last_s3;
		end
	end

endmodule

@@ rtl/motion_vector_local_outlier_mask_core.sv @@
// Top level of the motion vector local outlier mask: configuration,
// stream position, handshakes. Uses mvlom_pkg, mvlom_line_buf, mvlom_window, mvlom_judge.
//
//  Channel   Dir  Payload                                  Transfer when
//  s_*       in   tdata: vec_x, vec_y, prior_keep; tuser   s_tvalid && s_tready
//  m_*       out  tdata: keep; tlast: last_in_frame        m_tvalid && m_tready
//  cfg_*     in   cfg_index, cfg_data                      cfg_valid && cfg_ready
//
// One input item per cycle while not stalled; the result it releases, if any, passes
// s1, s2 and s3 to m_*. A vector's result is released by the item width+1 places later.
// Throughput is set by the line buffer memory: one read and one write a cycle.
// The whole pipeline stalls only while a result waits in the output register.
// After reset the line buffers need no clearing; configuration is always taken.
module motion_vector_local_outlier_mask_core import mvlom_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [11:0] vec_x, [23:12] vec_y, [24] prior_keep
	input  logic        s_tuser,   // [0] flush
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] keep
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	logic [FW_W-1:0]        width_q;
	logic [FH_W-1:0]        height_q;
	logic [ADDR_W-1:0]      col_q;
	logic [ROW_W-1:0]       row_q;
	logic [FW_W-1:0]        cfg_w;
	logic [FH_W-1:0]        cfg_h;
	logic [FW_W-1:0]        col_inc;
	logic [ROW_W-1:0]       h_plus1;
	logic                   adv;
	logic                   ignore;
	logic                   step;
	logic                   c_zero;
	pos_t                   pos_in;
	pos_t                   pos_s1;
	vec_t                   vec_in;
	logic                   valid_s1;
	vec_t                   up_s1;
	vec_t                   mid_s1;
	vec_t                   new_s1;
	logic                   valid_s3;
	logic signed [SUM_W-1:0] sum_x_s3;
	logic signed [SUM_W-1:0] sum_y_s3;
	logic [CNT_W-1:0]       cnt_s3;
	vec_t                   ctr_s3;
	logic                   last_s3;
	logic                   out_keep_q;

	// handshakes
	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;
	assign ignore    = s_tuser && (row_q == '0) && (col_q == '0);
	assign step      = s_tvalid && s_tready && !ignore;

	// clamped register values
	always_comb begin
		cfg_w = cfg_data[FW_W-1:0];
		if (cfg_w < FW_MIN) begin
			cfg_w = FW_MIN;
		end else if (cfg_w > FW_MAX) begin
			cfg_w = FW_MAX;
		end
		cfg_h = cfg_data[FH_W-1:0];
		if (cfg_h < FH_MIN) begin
			cfg_h = FH_MIN;
		end else if (cfg_h > FH_MAX) begin
			cfg_h = FH_MAX;
		end
	end

	// window center position of the current step
	assign c_zero  = (col_q == '0);
	assign h_plus1 = ROW_W'(height_q + FH_W'(1));
	always_comb begin
		if (c_zero) begin
			pos_in.emit   = (row_q >= ROW_W'(2)) && (row_q <= h_plus1);
			pos_in.top    = (row_q == ROW_W'(2));
			pos_in.bottom = (row_q == h_plus1);
		end else begin
			pos_in.emit   = (row_q >= ROW_W'(1)) && (row_q <= height_q);
			pos_in.top    = (row_q == ROW_W'(1));
			pos_in.bottom = (row_q == height_q);
		end
		pos_in.left  = (col_q == ADDR_W'(1));
		pos_in.right = c_zero;
		pos_in.last  = pos_in.emit && pos_in.bottom && c_zero;
	end

	// vectors past the last row are dropped
	assign vec_in = (row_q < height_q) ? vec_t'(s_tdata[ENTRY_W-1:0]) : '0;

	assign col_inc = {1'b0, col_q} + FW_W'(1);

	// registers and stream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FW_RESET;
			height_q <= FH_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IDX_WIDTH:  width_q  <= cfg_w;
				CFG_IDX_HEIGHT: height_q <= cfg_h;
				default:        width_q  <= width_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (pos_in.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= width_q) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_inc[ADDR_W-1:0];
			end
		end
	end

	// position travels alongside the memory read
	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1 <= pos_in;
		end
	end

	mvlom_line_buf u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.rd_en    (step),
		.rd_addr  (col_q),
		.vec_in   (vec_in),
		.valid_s1 (valid_s1),
		.up_s1    (up_s1),
		.mid_s1   (mid_s1),
		.new_s1   (new_s1)
	);

	mvlom_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.pos_s1   (pos_s1),
		.up_s1    (up_s1),
		.mid_s1   (mid_s1),
		.new_s1   (new_s1),
		.valid_s3 (valid_s3),
		.sum_x_s3 (sum_x_s3),
		.sum_y_s3 (sum_y_s3),
		.cnt_s3   (cnt_s3),
		.ctr_s3   (ctr_s3),
		.last_s3  (last_s3)
	);

	mvlom_judge u_judge (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.valid_s3    (valid_s3),
		.sum_x_s3    (sum_x_s3),
		.sum_y_s3    (sum_y_s3),
		.cnt_s3      (cnt_s3),
		.ctr_s3      (ctr_s3),
		.last_s3     (last_s3),
		.out_valid_q (m_tvalid),
		.out_keep_q  (out_keep_q),
		.out_last_q  (m_tlast)
	);

	assign m_tdata = {7'b0, out_keep_q};

`ifndef SYNTHESIS
	// column position never reaches the row width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < width_q)
		else $error("column position beyond field width");

	// row position stays within the field plus the flush rows
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_plus1)
		else $error("row position beyond field height");

	// the step that completes a frame rewinds the stream position
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		step && pos_in.last |=> (col_q == '0) && (row_q == '0))
		else $error("frame end did not rewind stream position");
`endif

endmodule
